@@ src/dcm_pkg.sv @@
// ----------------------------------------------------------------------------
// dcm_pkg
// Shared types, widths and helpers for the diphoton mass constraint pipeline.
// ----------------------------------------------------------------------------
package dcm_pkg;

  localparam int ENERGY_BITS   = 18;
  localparam int COS_FRAC_BITS = 15;
  localparam int COS_BITS      = COS_FRAC_BITS + 1;
  localparam int Z_BITS        = COS_FRAC_BITS + 1;
  localparam int MASS_BITS     = 36;
  localparam int CV_BITS       = 40;
  localparam int GD_BITS       = 48;
  localparam int GE_BITS       = 28;

  localparam int SQRT_STEPS = 4;
  localparam int DIV_STEPS  = 4;

  localparam logic [MASS_BITS-1:0] MASS_RESET = MASS_BITS'(18218);

  localparam logic [GD_BITS-1:0] GD_MAX = {1'b0, {(GD_BITS-1){1'b1}}};
  localparam logic [GD_BITS-1:0] GD_MIN = {1'b1, {(GD_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [COS_BITS-1:0] dir_x_first;
    logic signed [COS_BITS-1:0] dir_y_first;
    logic [ENERGY_BITS-1:0]     energy_first;
    logic signed [COS_BITS-1:0] dir_x_second;
    logic signed [COS_BITS-1:0] dir_y_second;
    logic [ENERGY_BITS-1:0]     energy_second;
  } pair_t;

  typedef struct packed {
    logic signed [CV_BITS-1:0] constraint_value;
    logic signed [GD_BITS-1:0] grad_x_first;
    logic signed [GD_BITS-1:0] grad_y_first;
    logic [GE_BITS-1:0]        grad_energy_first;
    logic signed [GD_BITS-1:0] grad_x_second;
    logic signed [GD_BITS-1:0] grad_y_second;
    logic [GE_BITS-1:0]        grad_energy_second;
    logic                      invalid;
  } result_t;

  typedef struct packed {
    logic               bad;
    logic [GD_BITS-1:0] value;
  } grad_t;

  // signed direction derivative from quotient magnitude, with saturation
  function automatic grad_t grad_sel(input logic z_zero, input logic neg,
                                     input logic ovf, input logic [GD_BITS-1:0] quo);
    grad_t r;
    r.bad   = 1'b0;
    r.value = quo;
    if (z_zero) begin
      r.bad   = 1'b1;
      r.value = neg ? GD_MIN : GD_MAX;
    end else if (neg) begin
      if (ovf || (quo > GD_MIN)) begin
        r.bad   = 1'b1;
        r.value = GD_MIN;
      end else begin
        r.value = -quo;
      end
    end else if (ovf || quo[GD_BITS-1]) begin
      r.bad   = 1'b1;
      r.value = GD_MAX;
    end
    return r;
  endfunction

endpackage

@@ src/dcm_sqrt.sv @@
// ----------------------------------------------------------------------------
// dcm_sqrt
// Pipelined integer square root, a few root bits per register stage.
// ----------------------------------------------------------------------------
module dcm_sqrt
  import dcm_pkg::*;
#(
  parameter int ROOT_BITS = Z_BITS,
  parameter int STEPS     = SQRT_STEPS
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [2*ROOT_BITS-1:0] radicand,
  output logic [ROOT_BITS-1:0]   root
);

  localparam int STAGES = (ROOT_BITS + STEPS - 1) / STEPS;
  localparam int RW     = STAGES * STEPS;

  logic [2*RW-1:0] rad_q  [STAGES];
  logic [RW+1:0]   rem_q  [STAGES];
  logic [RW-1:0]   root_q [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [2*RW-1:0] rad_in, rad_c;
    logic [RW+1:0]   rem_in, rem_c, trial;
    logic [RW-1:0]   root_in, root_c;

    if (g == 0) begin : g_head
      assign rad_in  = (2*RW)'(radicand);
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_tail
      assign rad_in  = rad_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
    end

    always_comb begin
      rad_c  = rad_in;
      rem_c  = rem_in;
      root_c = root_in;
      trial  = '0;
      for (int j = 0; j < STEPS; j++) begin
        rem_c = {rem_c[RW-1:0], rad_c[2*RW-1 -: 2]};
        rad_c = {rad_c[2*RW-3:0], 2'b00};
        trial = {root_c, 2'b01};
        if (rem_c >= trial) begin
          rem_c  = rem_c - trial;
          root_c = {root_c[RW-2:0], 1'b1};
        end else begin
          root_c = {root_c[RW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[g]  <= rad_c;
        rem_q[g]  <= rem_c;
        root_q[g] <= root_c;
      end
    end
  end

  assign root = root_q[STAGES-1][ROOT_BITS-1:0];

endmodule

@@ src/dcm_div.sv @@
// ----------------------------------------------------------------------------
// dcm_div
// Pipelined restoring divider, a few quotient bits per register stage.
// The high part of the dividend must be below the divisor.
// ----------------------------------------------------------------------------
module dcm_div
  import dcm_pkg::*;
#(
  parameter int DEN_BITS = Z_BITS,
  parameter int QUO_BITS = GD_BITS,
  parameter int STEPS    = DIV_STEPS
) (
  input  logic                clk,
  input  logic                en,
  input  logic [DEN_BITS-1:0] num_hi,
  input  logic [QUO_BITS-1:0] num_lo,
  input  logic [DEN_BITS-1:0] den,
  output logic [QUO_BITS-1:0] quo
);

  localparam int STAGES = (QUO_BITS + STEPS - 1) / STEPS;

  logic [DEN_BITS-1:0] rem_q [STAGES];
  logic [QUO_BITS-1:0] lo_q  [STAGES];
  logic [DEN_BITS-1:0] den_q [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [DEN_BITS-1:0] rem_in, den_in;
    logic [QUO_BITS-1:0] lo_in, lo_c;
    logic [DEN_BITS:0]   part;
    logic [DEN_BITS-1:0] rem_c;

    if (g == 0) begin : g_head
      assign rem_in = num_hi;
      assign lo_in  = num_lo;
      assign den_in = den;
    end else begin : g_tail
      assign rem_in = rem_q[g-1];
      assign lo_in  = lo_q[g-1];
      assign den_in = den_q[g-1];
    end

    always_comb begin
      rem_c = rem_in;
      lo_c  = lo_in;
      part  = '0;
      for (int j = 0; j < STEPS; j++) begin
        if (g * STEPS + j < QUO_BITS) begin
          part = {rem_c, lo_c[QUO_BITS-1]};
          if (part >= {1'b0, den_in}) begin
            part = part - {1'b0, den_in};
            lo_c = {lo_c[QUO_BITS-2:0], 1'b1};
          end else begin
            lo_c = {lo_c[QUO_BITS-2:0], 1'b0};
          end
          rem_c = part[DEN_BITS-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g] <= rem_c;
        lo_q[g]  <= lo_c;
        den_q[g] <= den_in;
      end
    end
  end

  assign quo = lo_q[STAGES-1];

endmodule

@@ src/diphoton_mass_constraint_gradient.sv @@
// ----------------------------------------------------------------------------
// diphoton_mass_constraint_gradient
// Two-photon invariant mass constraint and its six partial derivatives.
// ----------------------------------------------------------------------------
// The block takes one photon pair beat per clock while the output is not
// stalled and returns one result beat per pair, in order. The pipeline depth
// is set by the square-root pipeline rebuilding z (four stages of four root
// bits) and the four parallel dividers for the direction derivatives (twelve
// stages of four quotient bits); the rest is one register stage each for
// input capture, squares, cross products, k and numerators, partial products
// and their sum, and the output register. A stalled output holds the whole
// pipeline, and the input stalls in the same cycle.
module diphoton_mass_constraint_gradient
  import dcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pair_valid,
  output logic                 pair_stall,
  input  pair_t                pair,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [MASS_BITS-1:0] cfg_data
);

  localparam int E    = ENERGY_BITS;
  localparam int F    = COS_FRAC_BITS;
  localparam int SB   = 2*F + 3;
  localparam int RB   = 2*Z_BITS;
  localparam int XXB  = 2*COS_BITS;
  localparam int ZZB  = 2*Z_BITS;
  localparam int PZB  = 2*F + 3;
  localparam int KB   = 2*F + 3;
  localparam int MB   = 2*F + 2;
  localparam int MH   = MB / 2;
  localparam int MHI  = MB - MH;
  localparam int EB2  = 2*E;
  localparam int PB   = EB2 + MB;
  localparam int CMB  = PB - (2*F - 1);
  localparam int NNB  = PB - (F - 1);
  localparam int QB   = GD_BITS;
  localparam int NXB  = (NNB > QB + Z_BITS) ? NNB : QB + Z_BITS;
  localparam int HB   = NXB - QB;
  localparam int EKB  = E + MB;
  localparam int GEB  = EKB - (2*F - 9);
  localparam int GXB  = (GEB > GE_BITS + 1) ? GEB : GE_BITS + 1;
  localparam int CSA  = ((CMB > MASS_BITS) ? CMB : MASS_BITS) + 2;
  localparam int CSB  = (CSA > CV_BITS + 1) ? CSA : CV_BITS + 1;
  localparam int SQ   = (Z_BITS + SQRT_STEPS - 1) / SQRT_STEPS;
  localparam int DS   = (QB + DIV_STEPS - 1) / DIV_STEPS;
  localparam int LAT  = SQ + DS + 7;

  localparam logic signed [SB-1:0] S_ONE = {{(SB-2*F-1){1'b0}}, 1'b1, {(2*F){1'b0}}};
  localparam logic signed [KB-1:0] K_ONE = {{(KB-2*F-1){1'b0}}, 1'b1, {(2*F){1'b0}}};
  localparam logic signed [CSB-1:0] C_MAX =
    {{(CSB-CV_BITS+1){1'b0}}, {(CV_BITS-1){1'b1}}};
  localparam logic signed [CSB-1:0] C_MIN =
    {{(CSB-CV_BITS+1){1'b1}}, {(CV_BITS-1){1'b0}}};

  typedef struct packed {
    pair_t beat;
    logic  unphys;
  } sq_side_t;

  typedef struct packed {
    logic               bad;
    logic               z_zero1;
    logic               z_zero2;
    logic               k_neg;
    logic               x_neg;
    logic               x_pos;
    logic               y_neg;
    logic               y_pos;
    logic [3:0]         ovf;
    logic [CMB-1:0]     cm;
    logic [GE_BITS-1:0] ge1;
    logic [GE_BITS-1:0] ge2;
  } dv_side_t;

  logic                 adv;
  logic [LAT-1:0]       vld;
  logic [MASS_BITS-1:0] mass_squared;

  assign adv          = !result_valid || !result_stall;
  assign pair_stall   = !adv;
  assign result_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      mass_squared <= MASS_RESET;
    end else begin
      if (adv) begin
        vld <= {vld[LAT-2:0], pair_valid};
      end
      if (cfg_we) begin
        mass_squared <= cfg_data;
      end
    end
  end

  // input capture
  pair_t a_beat;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_beat <= pair;
    end
  end

  // squares and radicands
  logic signed [XXB-1:0] sq_x1, sq_y1, sq_x2, sq_y2;
  logic signed [SB-1:0]  s1, s2;
  pair_t                 b_beat;
  logic [RB-1:0]         b_rad1, b_rad2;
  logic                  b_unphys;

  assign sq_x1 = a_beat.dir_x_first * a_beat.dir_x_first;
  assign sq_y1 = a_beat.dir_y_first * a_beat.dir_y_first;
  assign sq_x2 = a_beat.dir_x_second * a_beat.dir_x_second;
  assign sq_y2 = a_beat.dir_y_second * a_beat.dir_y_second;
  assign s1    = S_ONE - SB'(sq_x1) - SB'(sq_y1);
  assign s2    = S_ONE - SB'(sq_x2) - SB'(sq_y2);

  always_ff @(posedge clk) begin
    if (adv) begin
      b_beat   <= a_beat;
      b_rad1   <= s1[SB-1] ? '0 : RB'(s1);
      b_rad2   <= s2[SB-1] ? '0 : RB'(s2);
      b_unphys <= s1[SB-1] | s2[SB-1];
    end
  end

  // z rebuild
  logic [Z_BITS-1:0] root1, root2;
  sq_side_t          sq_side [SQ];
  sq_side_t          sq_last;

  dcm_sqrt #(.ROOT_BITS(Z_BITS), .STEPS(SQRT_STEPS)) u_sqrt_first (
    .clk(clk), .en(adv), .radicand(b_rad1), .root(root1)
  );

  dcm_sqrt #(.ROOT_BITS(Z_BITS), .STEPS(SQRT_STEPS)) u_sqrt_second (
    .clk(clk), .en(adv), .radicand(b_rad2), .root(root2)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side[0] <= '{beat: b_beat, unphys: b_unphys};
      for (int i = 1; i < SQ; i++) begin
        sq_side[i] <= sq_side[i-1];
      end
    end
  end

  assign sq_last = sq_side[SQ-1];

  // cross products
  logic signed [Z_BITS:0] z1s, z2s;
  logic signed [XXB-1:0]  c_xx, c_yy;
  logic [ZZB-1:0]         c_zz;
  logic signed [PZB-1:0]  c_z2x1, c_x2z1, c_z2y1, c_y2z1;
  logic [EB2-1:0]         c_e12;
  logic [E-1:0]           c_e1, c_e2;
  logic [Z_BITS-1:0]      c_z1, c_z2;
  logic                   c_unphys;

  assign z1s = $signed({1'b0, root1});
  assign z2s = $signed({1'b0, root2});

  always_ff @(posedge clk) begin
    if (adv) begin
      c_xx     <= sq_last.beat.dir_x_first * sq_last.beat.dir_x_second;
      c_yy     <= sq_last.beat.dir_y_first * sq_last.beat.dir_y_second;
      c_zz     <= root1 * root2;
      c_z2x1   <= z2s * sq_last.beat.dir_x_first;
      c_x2z1   <= z1s * sq_last.beat.dir_x_second;
      c_z2y1   <= z2s * sq_last.beat.dir_y_first;
      c_y2z1   <= z1s * sq_last.beat.dir_y_second;
      c_e12    <= sq_last.beat.energy_first * sq_last.beat.energy_second;
      c_e1     <= sq_last.beat.energy_first;
      c_e2     <= sq_last.beat.energy_second;
      c_z1     <= root1;
      c_z2     <= root2;
      c_unphys <= sq_last.unphys;
    end
  end

  // k and derivative numerators
  logic signed [KB-1:0] k_c;
  logic signed [PZB-1:0] nx_c, ny_c;
  logic [MB-1:0]        d_kmag, d_magx, d_magy;
  logic                 d_kneg, d_xneg, d_xpos, d_yneg, d_ypos;
  logic [EB2-1:0]       d_e12;
  logic [E-1:0]         d_e1, d_e2;
  logic [Z_BITS-1:0]    d_z1, d_z2;
  logic                 d_unphys;

  assign k_c  = K_ONE - KB'(c_xx) - KB'(c_yy) - $signed(KB'(c_zz));
  assign nx_c = c_z2x1 - c_x2z1;
  assign ny_c = c_z2y1 - c_y2z1;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_kneg   <= k_c[KB-1];
      d_kmag   <= k_c[KB-1] ? MB'(-k_c) : MB'(k_c);
      d_xneg   <= nx_c[PZB-1];
      d_xpos   <= !nx_c[PZB-1] && (nx_c != '0);
      d_magx   <= nx_c[PZB-1] ? MB'(-nx_c) : MB'(nx_c);
      d_yneg   <= ny_c[PZB-1];
      d_ypos   <= !ny_c[PZB-1] && (ny_c != '0);
      d_magy   <= ny_c[PZB-1] ? MB'(-ny_c) : MB'(ny_c);
      d_e12    <= c_e12;
      d_e1     <= c_e1;
      d_e2     <= c_e2;
      d_z1     <= c_z1;
      d_z2     <= c_z2;
      d_unphys <= c_unphys;
    end
  end

  // partial products
  logic [EB2+MH-1:0]  e_pk_lo, e_px_lo, e_py_lo;
  logic [EB2+MHI-1:0] e_pk_hi, e_px_hi, e_py_hi;
  logic [EKB-1:0]     e_pe1, e_pe2;
  logic               e_kneg, e_xneg, e_xpos, e_yneg, e_ypos, e_unphys;
  logic [Z_BITS-1:0]  e_z1, e_z2;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_pk_lo  <= d_e12 * d_kmag[MH-1:0];
      e_pk_hi  <= d_e12 * d_kmag[MB-1:MH];
      e_px_lo  <= d_e12 * d_magx[MH-1:0];
      e_px_hi  <= d_e12 * d_magx[MB-1:MH];
      e_py_lo  <= d_e12 * d_magy[MH-1:0];
      e_py_hi  <= d_e12 * d_magy[MB-1:MH];
      e_pe1    <= d_e2 * d_kmag;
      e_pe2    <= d_e1 * d_kmag;
      e_kneg   <= d_kneg;
      e_xneg   <= d_xneg;
      e_xpos   <= d_xpos;
      e_yneg   <= d_yneg;
      e_ypos   <= d_ypos;
      e_z1     <= d_z1;
      e_z2     <= d_z2;
      e_unphys <= d_unphys;
    end
  end

  // full products, constraint magnitude, energy derivatives, overflow checks
  logic [PB-1:0]      pk, px, py;
  logic [NXB-1:0]     nx_ext, ny_ext;
  logic [GXB-1:0]     ge1_ext, ge2_ext;
  logic               ge1_over, ge2_over, z1_zero, z2_zero;
  logic [3:0]         ovf_c;
  logic [NXB-1:0]     f_nx, f_ny;
  logic [Z_BITS-1:0]  f_z1, f_z2;
  dv_side_t           f_side;

  assign pk = PB'(e_pk_lo) + (PB'(e_pk_hi) << MH);
  assign px = PB'(e_px_lo) + (PB'(e_px_hi) << MH);
  assign py = PB'(e_py_lo) + (PB'(e_py_hi) << MH);

  assign nx_ext = NXB'(px[PB-1:F-1]);
  assign ny_ext = NXB'(py[PB-1:F-1]);

  assign ovf_c[0] = nx_ext[NXB-1:QB] >= HB'(e_z1);
  assign ovf_c[1] = ny_ext[NXB-1:QB] >= HB'(e_z1);
  assign ovf_c[2] = nx_ext[NXB-1:QB] >= HB'(e_z2);
  assign ovf_c[3] = ny_ext[NXB-1:QB] >= HB'(e_z2);

  assign ge1_ext  = GXB'(e_pe1[EKB-1:2*F-9]);
  assign ge2_ext  = GXB'(e_pe2[EKB-1:2*F-9]);
  assign ge1_over = |ge1_ext[GXB-1:GE_BITS];
  assign ge2_over = |ge2_ext[GXB-1:GE_BITS];
  assign z1_zero  = (e_z1 == '0);
  assign z2_zero  = (e_z2 == '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      f_nx           <= nx_ext;
      f_ny           <= ny_ext;
      f_z1           <= e_z1;
      f_z2           <= e_z2;
      f_side.bad     <= e_unphys | z1_zero | z2_zero | e_kneg | ge1_over | ge2_over;
      f_side.z_zero1 <= z1_zero;
      f_side.z_zero2 <= z2_zero;
      f_side.k_neg   <= e_kneg;
      f_side.x_neg   <= e_xneg;
      f_side.x_pos   <= e_xpos;
      f_side.y_neg   <= e_yneg;
      f_side.y_pos   <= e_ypos;
      f_side.ovf     <= ovf_c;
      f_side.cm      <= pk[PB-1:2*F-1];
      f_side.ge1     <= e_kneg ? '0 : (ge1_over ? '1 : ge1_ext[GE_BITS-1:0]);
      f_side.ge2     <= e_kneg ? '0 : (ge2_over ? '1 : ge2_ext[GE_BITS-1:0]);
    end
  end

  // direction derivative dividers
  logic [QB-1:0] q_x1, q_y1, q_x2, q_y2;
  dv_side_t      dv_side [DS];
  dv_side_t      dv_last;

  dcm_div #(.DEN_BITS(Z_BITS), .QUO_BITS(QB), .STEPS(DIV_STEPS)) u_div_x_first (
    .clk(clk), .en(adv), .num_hi(f_nx[QB +: Z_BITS]), .num_lo(f_nx[QB-1:0]),
    .den(f_z1), .quo(q_x1)
  );

  dcm_div #(.DEN_BITS(Z_BITS), .QUO_BITS(QB), .STEPS(DIV_STEPS)) u_div_y_first (
    .clk(clk), .en(adv), .num_hi(f_ny[QB +: Z_BITS]), .num_lo(f_ny[QB-1:0]),
    .den(f_z1), .quo(q_y1)
  );

  dcm_div #(.DEN_BITS(Z_BITS), .QUO_BITS(QB), .STEPS(DIV_STEPS)) u_div_x_second (
    .clk(clk), .en(adv), .num_hi(f_nx[QB +: Z_BITS]), .num_lo(f_nx[QB-1:0]),
    .den(f_z2), .quo(q_x2)
  );

  dcm_div #(.DEN_BITS(Z_BITS), .QUO_BITS(QB), .STEPS(DIV_STEPS)) u_div_y_second (
    .clk(clk), .en(adv), .num_hi(f_ny[QB +: Z_BITS]), .num_lo(f_ny[QB-1:0]),
    .den(f_z2), .quo(q_y2)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side[0] <= f_side;
      for (int i = 1; i < DS; i++) begin
        dv_side[i] <= dv_side[i-1];
      end
    end
  end

  assign dv_last = dv_side[DS-1];

  // final assembly
  logic signed [CSB-1:0] cm_s, c_val;
  logic                  c_hi, c_lo;
  grad_t                 g_x1, g_y1, g_x2, g_y2;
  result_t               res_c;

  assign cm_s  = $signed(CSB'(dv_last.cm));
  assign c_val = (dv_last.k_neg ? -cm_s : cm_s) - $signed(CSB'(mass_squared));
  assign c_hi  = c_val > C_MAX;
  assign c_lo  = c_val < C_MIN;

  // second photon numerators are the first ones negated
  assign g_x1 = grad_sel(dv_last.z_zero1, dv_last.x_neg, dv_last.ovf[0], q_x1);
  assign g_y1 = grad_sel(dv_last.z_zero1, dv_last.y_neg, dv_last.ovf[1], q_y1);
  assign g_x2 = grad_sel(dv_last.z_zero2, dv_last.x_pos, dv_last.ovf[2], q_x2);
  assign g_y2 = grad_sel(dv_last.z_zero2, dv_last.y_pos, dv_last.ovf[3], q_y2);

  always_comb begin
    res_c.constraint_value   = c_hi ? C_MAX[CV_BITS-1:0] :
                               (c_lo ? C_MIN[CV_BITS-1:0] : c_val[CV_BITS-1:0]);
    res_c.grad_x_first       = g_x1.value;
    res_c.grad_y_first       = g_y1.value;
    res_c.grad_energy_first  = dv_last.ge1;
    res_c.grad_x_second      = g_x2.value;
    res_c.grad_y_second      = g_y2.value;
    res_c.grad_energy_second = dv_last.ge2;
    res_c.invalid            = dv_last.bad | c_hi | c_lo | g_x1.bad | g_y1.bad
                               | g_x2.bad | g_y2.bad;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res_c;
    end
  end

`ifndef ASSERT_OFF
  a_mass_reset: assert property (@(posedge clk) rst |=> (mass_squared == MASS_RESET))
    else $error("mass register not at default after reset");

  a_zero_z_flag: assert property (@(posedge clk) disable iff (rst)
    (adv && (dv_last.z_zero1 || dv_last.z_zero2)) |=> result.invalid)
    else $error("zero z beat left without invalid flag");

  a_valid_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(vld[LAT-2]))
    else $error("result beat appeared without a pipeline beat behind it");
`endif

endmodule

@@ verif/dcm_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dcm_checker
// Watches the pair, result and config ports of the diphoton mass constraint
// block. For every accepted pair beat it computes the expected constraint,
// gradients and invalid flag, queues them, and compares each result beat
// field by field against the oldest queued expectation.
// ----------------------------------------------------------------------------
module dcm_checker
  import dcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pair_valid,
  input  logic                 pair_stall,
  input  pair_t                pair,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  result_t              result,
  input  logic                 cfg_we,
  input  logic [MASS_BITS-1:0] cfg_data,
  output int                   errors,
  output int                   pending,
  output int                   n_results,
  output int                   n_invalid
);

  logic [MASS_BITS-1:0] mass_sq;
  result_t              expected_results[$];

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint z_of(longint x, longint y, inout bit bad);
    longint s;
    s = (64'sd1 <<< (2 * COS_FRAC_BITS)) - x * x - y * y;
    if (s < 0) begin
      bad = 1'b1;
      return 0;
    end
    return longint'(int_sqrt(unsigned'(s)));
  endfunction

  function automatic logic [GD_BITS-1:0] dir_grad(longint unsigned e12, longint num,
                                                 longint zden, inout bit bad);
    logic [127:0] mag;
    logic [127:0] q;
    if (zden <= 0) begin
      bad = 1'b1;
      return (num < 0) ? GD_MIN : GD_MAX;
    end
    mag = (num < 0) ? 128'(-num) : 128'(num);
    q = (128'(e12) * mag) / (128'(zden) << (COS_FRAC_BITS - 1));
    if (num < 0) begin
      if (q > (128'd1 << 47)) begin
        bad = 1'b1;
        return GD_MIN;
      end
      return -q[GD_BITS-1:0];
    end
    if (q > ((128'd1 << 47) - 1)) begin
      bad = 1'b1;
      return GD_MAX;
    end
    return q[GD_BITS-1:0];
  endfunction

  function automatic logic [GE_BITS-1:0] energy_grad(longint unsigned e, longint k,
                                                    inout bit bad);
    logic [127:0] w;
    if (k < 0) begin
      bad = 1'b1;
      return '0;
    end
    w = (128'(e) * 128'(k)) >> (2 * COS_FRAC_BITS - 9);
    if (w > ((128'd1 << GE_BITS) - 1)) begin
      bad = 1'b1;
      return {GE_BITS{1'b1}};
    end
    return w[GE_BITS-1:0];
  endfunction

  function automatic result_t predict_pair(pair_t p, logic [MASS_BITS-1:0] m);
    result_t r;
    bit bad;
    longint x1, y1, x2, y2, z1, z2, k, c;
    longint unsigned e1, e2, e12;
    logic [127:0] prod;
    bad = 1'b0;
    x1 = p.dir_x_first;
    y1 = p.dir_y_first;
    x2 = p.dir_x_second;
    y2 = p.dir_y_second;
    e1 = p.energy_first;
    e2 = p.energy_second;
    z1 = z_of(x1, y1, bad);
    z2 = z_of(x2, y2, bad);
    k = (64'sd1 <<< (2 * COS_FRAC_BITS)) - x1 * x2 - y1 * y2 - z1 * z2;
    e12 = e1 * e2;
    prod = (128'(e12) * ((k < 0) ? 128'(-k) : 128'(k))) >> (2 * COS_FRAC_BITS - 1);
    if (prod > (128'd1 << 62)) prod = 128'd1 << 62;
    c = (k < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    c = c - longint'({28'd0, m});
    if (z1 == 0 || z2 == 0) bad = 1'b1;
    if (c > (64'sd1 <<< 39) - 1) begin
      c = (64'sd1 <<< 39) - 1;
      bad = 1'b1;
    end
    if (c < -(64'sd1 <<< 39)) begin
      c = -(64'sd1 <<< 39);
      bad = 1'b1;
    end
    r.constraint_value   = c[CV_BITS-1:0];
    r.grad_x_first       = dir_grad(e12, z2 * x1 - x2 * z1, z1, bad);
    r.grad_y_first       = dir_grad(e12, z2 * y1 - y2 * z1, z1, bad);
    r.grad_x_second      = dir_grad(e12, z1 * x2 - x1 * z2, z2, bad);
    r.grad_y_second      = dir_grad(e12, z1 * y2 - y1 * z2, z2, bad);
    r.grad_energy_first  = energy_grad(e2, k, bad);
    r.grad_energy_second = energy_grad(e1, k, bad);
    r.invalid            = bad;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] exp);
    $display("%0t: result %0d field %s got %h expected %h", $realtime, n_results,
             field, got, exp);
    errors = errors + 1;
  endtask

  task automatic compare_beat(result_t got);
    result_t exp;
    if (expected_results.size() == 0) begin
      $display("%0t: result beat with nothing outstanding", $realtime);
      errors = errors + 1;
      return;
    end
    exp = expected_results.pop_front();
    if (got.constraint_value !== exp.constraint_value)
      report_mismatch("constraint_value", 64'(got.constraint_value),
                      64'(exp.constraint_value));
    if (got.grad_x_first !== exp.grad_x_first)
      report_mismatch("grad_x_first", 64'(got.grad_x_first), 64'(exp.grad_x_first));
    if (got.grad_y_first !== exp.grad_y_first)
      report_mismatch("grad_y_first", 64'(got.grad_y_first), 64'(exp.grad_y_first));
    if (got.grad_energy_first !== exp.grad_energy_first)
      report_mismatch("grad_energy_first", 64'(got.grad_energy_first),
                      64'(exp.grad_energy_first));
    if (got.grad_x_second !== exp.grad_x_second)
      report_mismatch("grad_x_second", 64'(got.grad_x_second), 64'(exp.grad_x_second));
    if (got.grad_y_second !== exp.grad_y_second)
      report_mismatch("grad_y_second", 64'(got.grad_y_second), 64'(exp.grad_y_second));
    if (got.grad_energy_second !== exp.grad_energy_second)
      report_mismatch("grad_energy_second", 64'(got.grad_energy_second),
                      64'(exp.grad_energy_second));
    if (got.invalid !== exp.invalid)
      report_mismatch("invalid", 64'(got.invalid), 64'(exp.invalid));
    if (exp.invalid) n_invalid = n_invalid + 1;
    n_results = n_results + 1;
  endtask

  initial begin
    errors = 0;
    n_results = 0;
    n_invalid = 0;
    mass_sq = MASS_RESET;
  end

  assign pending = expected_results.size();

  always @(posedge clk) begin
    if (rst) begin
      mass_sq <= MASS_RESET;
    end else begin
      if (pair_valid && !pair_stall) expected_results.push_back(predict_pair(pair, mass_sq));
      if (result_valid && !result_stall) compare_beat(result);
      if (cfg_we) mass_sq <= cfg_data;
    end
  end

endmodule

@@ verif/tb_diphoton_mass_constraint_gradient.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_diphoton_mass_constraint_gradient
// Drives photon pair beats through the mass constraint block under random
// gaps and output stalls, across several target mass settings, and lets the
// checker compare every result beat against its own prediction.
// ----------------------------------------------------------------------------
module tb_diphoton_mass_constraint_gradient;
  import dcm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  logic                 clk;
  logic                 rst;
  logic                 pair_valid;
  logic                 pair_stall;
  pair_t                pair;
  logic                 result_valid;
  logic                 result_stall;
  result_t              result;
  logic                 cfg_we;
  logic [MASS_BITS-1:0] cfg_data;

  int  errors, pending, n_results, n_invalid;
  int  cycles;
  bit  long_hold;
  bit  calm;
  int  n_settings;

  diphoton_mass_constraint_gradient u_top (
    .clk          (clk),
    .rst          (rst),
    .pair_valid   (pair_valid),
    .pair_stall   (pair_stall),
    .pair         (pair),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  dcm_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .pair_valid   (pair_valid),
    .pair_stall   (pair_stall),
    .pair         (pair),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending),
    .n_results    (n_results),
    .n_invalid    (n_invalid)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles = cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // result side: random stalls, occasional long hold-off
  initial begin
    int n;
    result_stall = 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        n = 120;
        long_hold = 1'b0;
      end else if (calm) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 3);
      end
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      forever begin
        @(negedge clk);
        if (result_valid) break;
      end
      @(posedge clk);
    end
  end

  task automatic send_pair(pair_t p);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      pair_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pair_valid <= 1'b1;
    pair <= p;
    forever begin
      @(negedge clk);
      if (!pair_stall) break;
    end
    @(posedge clk);
  endtask

  task automatic drain();
    pair_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mass(logic [MASS_BITS-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings = n_settings + 1;
  endtask

  function automatic logic signed [COS_BITS-1:0] cos_rand();
    return COS_BITS'($urandom);
  endfunction

  function automatic logic [ENERGY_BITS-1:0] energy_rand();
    int w;
    w = $urandom_range(1, ENERGY_BITS);
    return ENERGY_BITS'($urandom) & ENERGY_BITS'((64'd1 << w) - 1);
  endfunction

  // physical direction: pick x, then y within the unit circle
  task automatic dir_rand(output logic signed [COS_BITS-1:0] x,
                          output logic signed [COS_BITS-1:0] y);
    longint xx, ymax;
    x = cos_rand();
    if (x == -32768) x = 0;
    xx = x;
    ymax = 0;
    while ((ymax + 1) * (ymax + 1) <= (64'sd1 << 30) - xx * xx && ymax < 32767)
      ymax = ymax + 1;
    y = COS_BITS'($urandom_range(0, int'(ymax)));
    if ($urandom_range(0, 1)) y = -y;
  endtask

  function automatic pair_t mk(int x1, int y1, int e1, int x2, int y2, int e2);
    pair_t p;
    p.dir_x_first   = COS_BITS'(x1);
    p.dir_y_first   = COS_BITS'(y1);
    p.energy_first  = ENERGY_BITS'(e1);
    p.dir_x_second  = COS_BITS'(x2);
    p.dir_y_second  = COS_BITS'(y2);
    p.energy_second = ENERGY_BITS'(e2);
    return p;
  endfunction

  task automatic random_pairs(int n);
    pair_t p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        dir_rand(p.dir_x_first, p.dir_y_first);
        dir_rand(p.dir_x_second, p.dir_y_second);
        if ($urandom_range(0, 1)) begin
          p.dir_x_first  = -p.dir_x_first;
          p.dir_y_first  = -p.dir_y_first;
        end
      end else begin
        p.dir_x_first  = cos_rand();
        p.dir_y_first  = cos_rand();
        p.dir_x_second = cos_rand();
        p.dir_y_second = cos_rand();
      end
      p.energy_first  = energy_rand();
      p.energy_second = energy_rand();
      if (i == n / 2) long_hold = 1'b1;
      send_pair(p);
    end
  endtask

  initial begin
    rst = 1'b1;
    pair_valid = 1'b0;
    pair = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    long_hold = 1'b0;
    calm = 1'b0;
    n_settings = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners under the reset mass value
    send_pair(mk(0, 0, 0, 0, 0, 0));
    send_pair(mk(0, 0, 262143, 0, 0, 262143));
    send_pair(mk(10000, -5000, 1000, 10000, -5000, 2000));
    send_pair(mk(20000, 0, 262143, -20000, 0, 262143));
    send_pair(mk(-32768, 0, 500, 0, 0, 700));
    send_pair(mk(0, -32768, 500, 0, 32767, 700));
    send_pair(mk(32767, 32767, 300, 1000, 2000, 400));
    send_pair(mk(-32768, -32768, 262143, -32768, -32768, 262143));
    send_pair(mk(-32768, -32768, 1000, 32767, 32767, 1000));
    send_pair(mk(32767, 0, 262143, -32767, 0, 262143));
    send_pair(mk(32767, 181, 262143, 0, -32767, 262143));
    send_pair(mk(32767, -181, 200000, 100, 200, 150000));
    send_pair(mk(-32767, 0, 135, 32767, 0, 135));
    send_pair(mk(5000, 6000, 67, 5100, 6000, 68));
    send_pair(mk(-1, -1, 1, 1, 1, 1));
    send_pair(mk(23170, 23170, 131072, -23170, -23170, 131072));
    send_pair(mk(0, 0, 100000, 32767, 0, 100000));
    send_pair(mk(16384, 16384, 262143, 0, -1, 0));

    write_mass('0);
    random_pairs(120);
    write_mass({MASS_BITS{1'b1}});
    send_pair(mk(0, 0, 10, 0, 0, 10));
    send_pair(mk(32767, 0, 262143, -32767, 0, 262143));
    random_pairs(120);
    // wait for the pipeline to empty before resuming
    drain();
    calm = 1'b1;
    random_pairs(80);
    calm = 1'b0;
    write_mass(MASS_BITS'($urandom) | (MASS_BITS'($urandom) << 32));
    random_pairs(120);
    write_mass(MASS_BITS'(18218));
    random_pairs(140);

    drain();
    $display("checked %0d result beats (%0d flagged invalid) over %0d mass settings",
             n_results, n_invalid, n_settings);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d beats still outstanding", errors, pending);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/dcm_pkg.sv
src/dcm_sqrt.sv
src/dcm_div.sv
src/diphoton_mass_constraint_gradient.sv
verif/dcm_checker.sv
verif/tb_diphoton_mass_constraint_gradient.sv
